### sv/lcrf_pkg.sv
package lcrf_pkg;

  // sizing
  localparam int STORE_WORDS = 16384;
  localparam int PORT_COUNT  = 3;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int PIDX_W      = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int WIDX_STEPS  = (16384 + STORE_WORDS - 1) / STORE_WORDS - 1;
  localparam logic [14:0] WORDS_15   = 15'(STORE_WORDS);
  localparam logic [3:0]  PORT_LIMIT = 4'(PORT_COUNT);

  // full bus addresses with special meaning
  localparam logic [31:0] A_VERSION = 32'h1f80_8410;
  localparam logic [31:0] A_CONTROL = 32'h1f80_8400;
  localparam logic [31:0] A_PHYACC  = 32'h1f80_8414;
  localparam logic [31:0] A_STAT0   = 32'h1f80_8420;
  localparam logic [31:0] A_STAT1   = 32'h1f80_8428;
  localparam logic [31:0] A_STAT2   = 32'h1f80_8430;

  // store indices of the special words
  localparam logic [ADDR_W-1:0] IDX_CTRL  = ADDR_W'((32'h8400 >> 2) % STORE_WORDS);
  localparam logic [ADDR_W-1:0] IDX_PHY   = ADDR_W'((32'h8414 >> 2) % STORE_WORDS);
  localparam logic [ADDR_W-1:0] IDX_ISTAT = ADDR_W'((32'h8420 >> 2) % STORE_WORDS);
  localparam logic [ADDR_W-1:0] IDX_IMASK = ADDR_W'((32'h8424 >> 2) % STORE_WORDS);
  localparam logic [ADDR_W-1:0] IDX_LAST  = ADDR_W'(STORE_WORDS - 1);

  // word constants
  localparam logic [31:0] CTRL_RESET   = 32'hffc0_0001;
  localparam logic [31:0] CTRL_KEEP    = 32'h003f_0001;
  localparam logic [31:0] PHY_KEEP     = 32'h0000_0fff;
  localparam logic [31:0] IRQ_BIT      = 32'h4000_0000;
  localparam logic [31:0] VERSION_WORD = 32'h0000_0008;

  // bank codes in the low bits of the bank select
  localparam logic [2:0] BANK_PORT  = 3'd0;
  localparam logic [2:0] BANK_VID   = 3'd1;
  localparam logic [2:0] BANK_FIXED = 3'd3;
  localparam logic [2:0] BANK_VDE   = 3'd7;
  localparam logic [7:0] FIXED_BYTE = 8'h02;

  // phy byte registers and banked entries
  localparam logic [2:0] PHY_MASKED   = 3'd4;
  localparam logic [2:0] PHY_BANKSEL  = 3'd7;
  localparam logic [7:0] PHY_WRITABLE = 8'b1010_0010;
  localparam logic [2:0] ENT_FIRST    = 3'd0;
  localparam logic [2:0] ENT_SECOND   = 3'd1;

  // access kinds of a captured word
  typedef enum logic [2:0] {
    K_READ,
    K_VERSION,
    K_WRITE,
    K_CTRL,
    K_STAT,
    K_PHY
  } kind_t;

  // datapath steps ordered by the controller
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_CLEAR,
    STEP_CAPTURE,
    STEP_ISSUE,
    STEP_MERGE,
    STEP_ISTAT,
    STEP_IMASK,
    STEP_RESULT
  } step_t;

  typedef struct packed {
    step_t             step;
    logic [ADDR_W-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  ind_rd;
    logic  out_free;
  } sts_t;

  // word index of a bus address, reduced modulo the store depth
  function automatic logic [ADDR_W-1:0] widx(input logic [15:0] a);
    logic [14:0] v;
    v = {1'b0, a[15:2]};
    for (int k = 0; k < WIDX_STEPS; k++) begin
      if (v >= WORDS_15) v = v - WORDS_15;
    end
    return v[ADDR_W-1:0];
  endfunction

endpackage

### sv/lcrf_ram.sv
module lcrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### sv/lcrf_bank.sv
module lcrf_bank (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] reg_sel,
  input  logic       wr_en,
  input  logic [7:0] wr_byte,
  output logic [7:0] rd_byte
);

  logic [7:0] phy_r   [8];
  logic [7:0] port0_r [lcrf_pkg::PORT_COUNT];
  logic [7:0] port1_r [lcrf_pkg::PORT_COUNT];
  logic [7:0] vde0_r;

  logic [2:0]                    entry;
  logic [2:0]                    bank;
  logic [3:0]                    port;
  logic                          port_ok;
  logic [lcrf_pkg::PIDX_W-1:0]   pidx;

  assign entry   = reg_sel[2:0];
  assign bank    = phy_r[lcrf_pkg::PHY_BANKSEL][2:0];
  assign port    = phy_r[lcrf_pkg::PHY_BANKSEL][7:4];
  assign port_ok = (port < lcrf_pkg::PORT_LIMIT);
  assign pidx    = port[lcrf_pkg::PIDX_W-1:0];

  // indirect read mux
  always_comb begin
    rd_byte = 8'h00;
    if (!reg_sel[3]) begin
      rd_byte = phy_r[entry];
    end else begin
      case (bank)
        lcrf_pkg::BANK_PORT: begin
          if (port_ok && entry == lcrf_pkg::ENT_FIRST) rd_byte = port0_r[pidx];
          else if (port_ok && entry == lcrf_pkg::ENT_SECOND) rd_byte = port1_r[pidx];
        end
        lcrf_pkg::BANK_VID: rd_byte = (entry == lcrf_pkg::ENT_FIRST) ? 8'h01 : 8'h00;
        lcrf_pkg::BANK_FIXED: rd_byte = lcrf_pkg::FIXED_BYTE;
        lcrf_pkg::BANK_VDE: rd_byte = (entry == lcrf_pkg::ENT_FIRST) ? vde0_r : 8'h00;
        default: rd_byte = 8'h00;
      endcase
    end
  end

  // reset values and byte writes, some of them masked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k < 8; k++) phy_r[k] <= 8'h00;
      phy_r[0] <= 8'hc1;
      for (int k = 0; k < lcrf_pkg::PORT_COUNT; k++) begin
        port0_r[k] <= (k == 0) ? 8'he5 : 8'h00;
        port1_r[k] <= 8'h00;
      end
      vde0_r <= 8'h00;
    end else if (wr_en) begin
      if (!reg_sel[3]) begin
        if (entry == lcrf_pkg::PHY_MASKED)
          phy_r[entry] <= (phy_r[entry] & 8'h1c) | (wr_byte & 8'he3);
        else if (lcrf_pkg::PHY_WRITABLE[entry])
          phy_r[entry] <= wr_byte;
      end else if (bank == lcrf_pkg::BANK_PORT) begin
        if (port_ok && entry == lcrf_pkg::ENT_FIRST)
          port0_r[pidx] <= (port0_r[pidx] & 8'h7f) | (wr_byte & 8'h80);
        else if (port_ok && entry == lcrf_pkg::ENT_SECOND)
          port1_r[pidx] <= (port1_r[pidx] & 8'h07) | (wr_byte & 8'hf8);
      end else if (bank == lcrf_pkg::BANK_VDE && entry == lcrf_pkg::ENT_FIRST) begin
        vde0_r <= wr_byte;
      end
    end
  end

endmodule

### sv/lcrf_dp.sv
module lcrf_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  lcrf_pkg::cmd_t   cmd,
  output lcrf_pkg::sts_t   sts,
  input  logic [63:0]      in_tdata,
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata
);

  logic                          func_r;
  logic [31:0]                   addr_r;
  logic [31:0]                   wdata_r;
  logic [31:0]                   res_rdata_r;
  logic                          res_irq_r;
  logic [31:0]                   p_r;
  logic [31:0]                   istat_r;
  logic                          out_valid_r;
  logic [31:0]                   out_rdata_r;
  logic                          out_irq_r;

  lcrf_pkg::kind_t               kind;
  logic [lcrf_pkg::ADDR_W-1:0]   idx;
  logic                          out_free;

  logic                          mem_we;
  logic [lcrf_pkg::ADDR_W-1:0]   mem_waddr;
  logic [31:0]                   mem_wdata;
  logic [lcrf_pkg::ADDR_W-1:0]   mem_raddr;
  logic [31:0]                   mem_rdata;

  logic                          bank_we;
  logic [7:0]                    bank_byte;
  logic [31:0]                   p0;
  logic [31:0]                   p1;

  // access decode on the full address
  always_comb begin
    if (!func_r) begin
      kind = (addr_r == lcrf_pkg::A_VERSION) ? lcrf_pkg::K_VERSION : lcrf_pkg::K_READ;
    end else if (addr_r == lcrf_pkg::A_CONTROL) begin
      kind = lcrf_pkg::K_CTRL;
    end else if (addr_r == lcrf_pkg::A_PHYACC) begin
      kind = lcrf_pkg::K_PHY;
    end else if (addr_r == lcrf_pkg::A_STAT0 || addr_r == lcrf_pkg::A_STAT1 ||
                 addr_r == lcrf_pkg::A_STAT2) begin
      kind = lcrf_pkg::K_STAT;
    end else begin
      kind = lcrf_pkg::K_WRITE;
    end
  end

  assign idx      = lcrf_pkg::widx(addr_r[15:0]);
  assign out_free = !out_valid_r || out_tready;

  assign sts.kind     = kind;
  assign sts.ind_rd   = wdata_r[31];
  assign sts.out_free = out_free;

  // phy access word: new upper bits, then indirect read result
  assign p0 = (mem_rdata & lcrf_pkg::PHY_KEEP) | (wdata_r & ~lcrf_pkg::PHY_KEEP);
  assign p1 = {1'b0, p0[30:12], wdata_r[27:24], bank_byte};

  lcrf_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .reg_sel (wdata_r[27:24]),
    .wr_en   (bank_we),
    .wr_byte (wdata_r[23:16]),
    .rd_byte (bank_byte)
  );

  lcrf_ram #(
    .WIDTH (32),
    .DEPTH (lcrf_pkg::STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // store port and bank write steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = 32'h0;
    mem_raddr = idx;
    bank_we   = 1'b0;
    case (cmd.step)
      lcrf_pkg::STEP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cmd.clr_addr;
        mem_wdata = (cmd.clr_addr == lcrf_pkg::IDX_CTRL) ? lcrf_pkg::CTRL_RESET : 32'h0;
      end
      lcrf_pkg::STEP_ISSUE: begin
        if (kind == lcrf_pkg::K_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = wdata_r;
        end
      end
      lcrf_pkg::STEP_MERGE: begin
        mem_raddr = lcrf_pkg::IDX_ISTAT;
        case (kind)
          lcrf_pkg::K_CTRL: begin
            mem_we    = 1'b1;
            mem_wdata = (mem_rdata & lcrf_pkg::CTRL_KEEP) | (wdata_r & ~lcrf_pkg::CTRL_KEEP);
          end
          lcrf_pkg::K_STAT: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~wdata_r;
          end
          lcrf_pkg::K_PHY: begin
            if (!wdata_r[31]) begin
              mem_we    = 1'b1;
              mem_wdata = wdata_r[30] ? (p0 & ~lcrf_pkg::IRQ_BIT) : p0;
              bank_we   = wdata_r[30];
            end
          end
          default: ;
        endcase
      end
      lcrf_pkg::STEP_ISTAT: begin
        mem_we    = 1'b1;
        mem_waddr = lcrf_pkg::IDX_ISTAT;
        mem_wdata = mem_rdata | lcrf_pkg::IRQ_BIT;
        mem_raddr = lcrf_pkg::IDX_IMASK;
      end
      lcrf_pkg::STEP_IMASK: begin
        mem_we    = 1'b1;
        mem_waddr = lcrf_pkg::IDX_PHY;
        mem_wdata = wdata_r[30] ? (p_r & ~lcrf_pkg::IRQ_BIT) : p_r;
        bank_we   = wdata_r[30];
      end
      default: ;
    endcase
  end

  // captured word and working registers
  always_ff @(posedge clk) begin
    case (cmd.step)
      lcrf_pkg::STEP_CAPTURE: begin
        func_r  <= in_tuser;
        addr_r  <= in_tdata[31:0];
        wdata_r <= in_tdata[63:32];
      end
      lcrf_pkg::STEP_ISSUE: begin
        res_rdata_r <= (kind == lcrf_pkg::K_VERSION) ? lcrf_pkg::VERSION_WORD : 32'h0;
        res_irq_r   <= 1'b0;
      end
      lcrf_pkg::STEP_MERGE: begin
        if (kind == lcrf_pkg::K_READ) res_rdata_r <= mem_rdata;
        p_r <= p1;
      end
      lcrf_pkg::STEP_ISTAT: begin
        istat_r <= mem_rdata | lcrf_pkg::IRQ_BIT;
      end
      lcrf_pkg::STEP_IMASK: begin
        res_irq_r <= |(istat_r & mem_rdata);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step == lcrf_pkg::STEP_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == lcrf_pkg::STEP_RESULT && out_free) begin
      out_rdata_r <= res_rdata_r;
      out_irq_r   <= res_irq_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_irq_r, out_rdata_r};

endmodule

### sv/lcrf_ctrl.sv
module lcrf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lcrf_pkg::sts_t sts,
  output lcrf_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_MERGE,
    S_ISTAT,
    S_IMASK,
    S_RESULT
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [lcrf_pkg::ADDR_W-1:0] clr_cnt_r;
  logic [lcrf_pkg::ADDR_W-1:0] clr_cnt_nxt;
  logic                        rmw;

  // kinds that need the old store word
  assign rmw = (sts.kind == lcrf_pkg::K_READ) || (sts.kind == lcrf_pkg::K_CTRL) ||
               (sts.kind == lcrf_pkg::K_STAT) || (sts.kind == lcrf_pkg::K_PHY);

  // next state and step command
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    cmd.step     = lcrf_pkg::STEP_NONE;
    cmd.clr_addr = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        cmd.step    = lcrf_pkg::STEP_CLEAR;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == lcrf_pkg::IDX_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.step  = lcrf_pkg::STEP_CAPTURE;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.step  = lcrf_pkg::STEP_ISSUE;
        state_nxt = rmw ? S_MERGE : S_RESULT;
      end
      S_MERGE: begin
        cmd.step  = lcrf_pkg::STEP_MERGE;
        state_nxt = (sts.kind == lcrf_pkg::K_PHY && sts.ind_rd) ? S_ISTAT : S_RESULT;
      end
      S_ISTAT: begin
        cmd.step  = lcrf_pkg::STEP_ISTAT;
        state_nxt = S_IMASK;
      end
      S_IMASK: begin
        cmd.step  = lcrf_pkg::STEP_IMASK;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        cmd.step = lcrf_pkg::STEP_RESULT;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

### sv/link_controller_register_file.sv
// channel  dir  ports                       word contents
// in       in   in_tvalid/tready/tdata/tuser  tdata: addr, wdata; tuser: func
// out      out  out_tvalid/tready/tdata       tdata: rdata, irq_pulse
//
// from one accept to the next, a plain write or a version read passes the issue
// and result steps, a read or read-modify-write the issue, merge and result steps,
// and a phy access write with indirect read also the istat and imask steps before
// result; the store's registered read sets these steps
// after reset the store is swept once, one word a cycle, over all STORE_WORDS
// words (16384), during which no word is accepted
// one word is in flight at a time; a finished result waits in the output
// register while the next word is accepted, and a result still held there
// by out_tready keeps the next one in its last step
module link_controller_register_file (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] addr, [63:32] wdata
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] rdata, [32] irq_pulse, [39:33] zero
);

  lcrf_pkg::cmd_t cmd;
  lcrf_pkg::sts_t sts;

  lcrf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lcrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

endmodule
